@@ rtl/flow_table_wildcard_lookup_assert.svh @@
// Assertion macros for the flow table lookup block.
`ifndef FLOW_TABLE_WILDCARD_LOOKUP_ASSERT_SVH
`define FLOW_TABLE_WILDCARD_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
`define FTWL_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define FTWL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define FTWL_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define FTWL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

@@ rtl/ftwl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table lookup package
// Types, command codes and the entry match function.
// ----------------------------------------------------------------------------
package ftwl_pkg;

    localparam int DefTableDepth = 16;
    localparam logic [15:0] NormalPort = 16'hfffa;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  slot;
        logic [15:0] in_port;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [18:0] vlan_info;
        logic [15:0] eth_type;
        logic [15:0] tos_proto;
        logic [63:0] ip_pair;
        logic [31:0] l4_ports;
        logic [21:0] wild_mask;
        logic [31:0] prio_action;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic        exact;
        logic [3:0]  hit_index;
        logic [15:0] out_port;
        logic [15:0] hit_priority;
    } out_item_t;

    typedef struct packed {
        logic [15:0] in_port;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [18:0] vlan;
        logic [15:0] eth_type;
        logic [15:0] tos_proto;
        logic [63:0] ip_pair;
        logic [31:0] l4_ports;
        logic [21:0] wildcards;
        logic [15:0] prio;
        logic [15:0] out_port;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } scan_state_t;

    function automatic logic [31:0] prefix_mask(input logic [5:0] count);
        logic [31:0] m;
        m = 32'hffff_ffff << count[4:0];
        if (count[5]) begin
            m = '0;
        end
        return m;
    endfunction

    function automatic logic entry_match(input entry_t e, input in_item_t k);
        logic [21:0] w;
        logic        ok;
        w  = e.wildcards;
        ok = 1'b1;
        if (!w[0] && k.in_port != e.in_port) ok = 1'b0;
        if (!w[2] && k.src_mac != e.src_mac) ok = 1'b0;
        if (!w[3] && k.dst_mac != e.dst_mac) ok = 1'b0;
        if (!w[1] && k.vlan_info[15:0] != e.vlan[15:0]) ok = 1'b0;
        if (!w[1] && !w[20] && k.vlan_info[18:16] != e.vlan[18:16]) ok = 1'b0;
        if (!w[4] && k.eth_type != e.eth_type) ok = 1'b0;
        if (!w[21] && k.tos_proto[15:8] != e.tos_proto[15:8]) ok = 1'b0;
        if (!w[5] && k.tos_proto[7:0] != e.tos_proto[7:0]) ok = 1'b0;
        if (((k.ip_pair[63:32] ^ e.ip_pair[63:32]) & prefix_mask(w[13:8])) != '0) ok = 1'b0;
        if (((k.ip_pair[31:0] ^ e.ip_pair[31:0]) & prefix_mask(w[19:14])) != '0) ok = 1'b0;
        if (!w[6] && k.l4_ports[31:16] != e.l4_ports[31:16]) ok = 1'b0;
        if (!w[7] && k.l4_ports[15:0] != e.l4_ports[15:0]) ok = 1'b0;
        return ok;
    endfunction

endpackage

@@ rtl/ftwl_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table command queue
// Two-entry queue between the command front end and the table engine.
// ----------------------------------------------------------------------------
module ftwl_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  ftwl_pkg::in_item_t  wr_data,
    output logic                rd_valid,
    input  logic                rd_ready,
    output ftwl_pkg::in_item_t  rd_data
);
    import ftwl_pkg::*;
`include "flow_table_wildcard_lookup_assert.svh"

    in_item_t   mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (do_wr) wptr_reg <= ~wptr_reg;
            if (do_rd) rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

    `FTWL_ASSERT_IMPL(a_cnt_range, aclk, aresetn, (cnt_reg <= 2'd2), "queue count out of range")
    `FTWL_ASSERT_NEXT(a_full_hold, aclk, aresetn, (cnt_reg == 2'd2 && !do_rd), (cnt_reg == 2'd2), "full queue lost a beat")
    `FTWL_ASSERT_IMPL(a_ptr_sync, aclk, aresetn, ((cnt_reg == 2'd1) == (wptr_reg != rptr_reg)), "queue pointers disagree with count")
endmodule

@@ rtl/ftwl_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table engine
// Holds the entries, applies writes and clears, scans one entry per cycle.
// ----------------------------------------------------------------------------
module ftwl_engine #(
    parameter int TABLE_DEPTH = ftwl_pkg::DefTableDepth
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ftwl_pkg::in_item_t  cmd_data,
    output logic                res_valid,
    input  logic                res_ready,
    output ftwl_pkg::out_item_t res_data
);
    import ftwl_pkg::*;
`include "flow_table_wildcard_lookup_assert.svh"

    localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CntW = $clog2(TABLE_DEPTH + 1);

    entry_t              tbl_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                init0_reg;

    scan_state_t state_reg, state_next;
    in_item_t    key_reg;
    logic [CntW-1:0] idx_reg;
    entry_t      rd_reg;
    logic        rd_live_reg;
    logic [CntW-1:0] rd_idx_reg;
    logic        found_reg, exact_reg;
    logic [IdxW-1:0] best_reg;
    logic [15:0] best_prio_reg, best_port_reg;
    out_item_t   res_reg;
    logic        res_valid_reg;

    logic        take, slot_ok, cand_match, scan_end, stop;
    entry_t      cand, wr_entry, rst_entry;
    out_item_t   done_res;
    logic [IdxW-1:0] wslot;

    assign take      = cmd_valid && cmd_ready;
    assign cmd_ready = (state_reg == ST_IDLE) && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    assign slot_ok = ({28'd0, cmd_data.slot} < 32'(TABLE_DEPTH));
    assign wslot   = IdxW'(cmd_data.slot);

    always_comb begin
        wr_entry           = '0;
        wr_entry.in_port   = cmd_data.in_port;
        wr_entry.src_mac   = cmd_data.src_mac;
        wr_entry.dst_mac   = cmd_data.dst_mac;
        wr_entry.vlan      = cmd_data.vlan_info;
        wr_entry.eth_type  = cmd_data.eth_type;
        wr_entry.tos_proto = cmd_data.tos_proto;
        wr_entry.ip_pair   = cmd_data.ip_pair;
        wr_entry.l4_ports  = cmd_data.l4_ports;
        wr_entry.wildcards = cmd_data.wild_mask;
        wr_entry.prio      = cmd_data.prio_action[31:16];
        wr_entry.out_port  = cmd_data.prio_action[15:0];
        rst_entry           = '0;
        rst_entry.wildcards = '1;
        rst_entry.prio      = 16'd1;
        rst_entry.out_port  = NormalPort;
    end

    always_ff @(posedge aclk) begin
        if (take && cmd_data.cmd == CMD_WRITE && slot_ok) begin
            tbl_mem[wslot] <= wr_entry;
        end
        if (idx_reg < CntW'(TABLE_DEPTH)) begin
            rd_reg <= tbl_mem[idx_reg[IdxW-1:0]];
        end
    end

    always_comb begin
        cand = rd_reg;
        if (!init0_reg && rd_idx_reg == '0) begin
            cand = rst_entry;
        end
        cand_match = rd_live_reg && valid_reg[rd_idx_reg[IdxW-1:0]]
                     && entry_match(cand, key_reg);
        stop     = cand_match && (cand.wildcards == '0);
        scan_end = rd_live_reg && (rd_idx_reg == CntW'(TABLE_DEPTH - 1));
    end

    always_comb begin
        done_res = '0;
        if (found_reg) begin
            done_res.hit          = 1'b1;
            done_res.exact        = exact_reg;
            done_res.hit_index    = 4'(best_reg);
            done_res.out_port     = best_port_reg;
            done_res.hit_priority = best_prio_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take && cmd_data.cmd == CMD_LOOKUP) state_next = ST_SCAN;
            ST_SCAN: if (stop || scan_end) state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= TABLE_DEPTH'(1);
            init0_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            rd_live_reg   <= 1'b0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            exact_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (res_valid_reg && res_ready) res_valid_reg <= 1'b0;
            if (take && cmd_data.cmd == CMD_WRITE && slot_ok) begin
                valid_reg[wslot] <= 1'b1;
                if (cmd_data.slot == 4'd0) init0_reg <= 1'b1;
            end
            if (take && cmd_data.cmd == CMD_CLEAR && slot_ok) begin
                valid_reg[wslot] <= 1'b0;
            end
            if (take && cmd_data.cmd != CMD_LOOKUP) begin
                res_reg       <= '0;
                res_valid_reg <= 1'b1;
            end
            if (take && cmd_data.cmd == CMD_LOOKUP) begin
                key_reg     <= cmd_data;
                idx_reg     <= '0;
                rd_live_reg <= 1'b0;
                found_reg   <= 1'b0;
                exact_reg   <= 1'b0;
            end
            if (state_reg == ST_SCAN) begin
                rd_live_reg <= (idx_reg < CntW'(TABLE_DEPTH)) && !stop && !scan_end;
                rd_idx_reg  <= idx_reg;
                idx_reg     <= idx_reg + CntW'(1);
                if (cand_match && (stop || !found_reg || cand.prio >= best_prio_reg)) begin
                    found_reg     <= 1'b1;
                    exact_reg     <= stop;
                    best_reg      <= rd_idx_reg[IdxW-1:0];
                    best_prio_reg <= cand.prio;
                    best_port_reg <= cand.out_port;
                end
            end
            if (state_reg == ST_DONE) begin
                res_valid_reg <= 1'b1;
                res_reg       <= done_res;
            end
        end
    end

    `FTWL_ASSERT_IMPL(a_no_take_busy, aclk, aresetn, (!(take && state_reg != ST_IDLE)), "command taken during scan")
    `FTWL_ASSERT_NEXT(a_done_result, aclk, aresetn, (state_reg == ST_DONE), (res_valid_reg), "scan ended without a result")
    `FTWL_ASSERT_IMPL(a_exact_found, aclk, aresetn, (!exact_reg || found_reg), "exact flag without a hit")
endmodule

@@ rtl/flow_table_wildcard_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table wildcard lookup
// OpenFlow 1.0 style flow table with write, clear and wildcard lookup.
// ----------------------------------------------------------------------------
// A beat is presented to the engine in the cycle after it enters the queue. A
// write, clear or unused command gives an all-zero result in the cycle after
// the engine takes it; a lookup scans the table one entry per cycle and its
// result is registered when the scan ends, which is early when an exact entry
// hits. The engine takes its next beat only after the result has been
// accepted, so the scan length sets the rate. A two-beat queue lets the input
// side take beats while the engine is busy.
module flow_table_wildcard_lookup #(
    parameter int TABLE_DEPTH = ftwl_pkg::DefTableDepth
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ftwl_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ftwl_pkg::out_item_t m_data
);
    import ftwl_pkg::*;

    in_item_t q_data;
    logic     q_valid, q_ready;

    ftwl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (s_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    ftwl_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd_data  (q_data),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res_data  (m_data)
    );
endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table lookup testbench
// Drives write, clear and lookup beats into the flow table and compares every
// result with a behavioral copy of the table kept inside a scoreboard class.
// ----------------------------------------------------------------------------
module testbench;
    import ftwl_pkg::*;

    localparam int Depth = 16;
    localparam int WatchdogLimit = 20000;

    class flow_scoreboard;
        entry_t    table_q[Depth];
        bit        live[Depth];
        out_item_t pending[$];
        int        errors;
        int        lookups;
        int        hits;
        int        exact_hits;

        function void clear_table();
            for (int i = 0; i < Depth; i++) begin
                table_q[i] = '0;
                live[i] = 1'b0;
            end
            live[0] = 1'b1;
            table_q[0].wildcards = '1;
            table_q[0].prio = 16'd1;
            table_q[0].out_port = NormalPort;
        endfunction

        function bit key_matches(entry_t e, in_item_t k);
            logic [21:0] w;
            logic [31:0] sm;
            logic [31:0] dm;
            w = e.wildcards;
            sm = (w[13:8] >= 6'd32) ? 32'd0 : (32'hffff_ffff << w[13:8]);
            dm = (w[19:14] >= 6'd32) ? 32'd0 : (32'hffff_ffff << w[19:14]);
            if (!w[0] && k.in_port !== e.in_port) return 1'b0;
            if (!w[2] && k.src_mac !== e.src_mac) return 1'b0;
            if (!w[3] && k.dst_mac !== e.dst_mac) return 1'b0;
            if (!w[1] && k.vlan_info[15:0] !== e.vlan[15:0]) return 1'b0;
            if (!w[1] && !w[20] && k.vlan_info[18:16] !== e.vlan[18:16]) return 1'b0;
            if (!w[4] && k.eth_type !== e.eth_type) return 1'b0;
            if (!w[21] && k.tos_proto[15:8] !== e.tos_proto[15:8]) return 1'b0;
            if (!w[5] && k.tos_proto[7:0] !== e.tos_proto[7:0]) return 1'b0;
            if (((k.ip_pair[63:32] ^ e.ip_pair[63:32]) & sm) != 0) return 1'b0;
            if (((k.ip_pair[31:0] ^ e.ip_pair[31:0]) & dm) != 0) return 1'b0;
            if (!w[6] && k.l4_ports[31:16] !== e.l4_ports[31:16]) return 1'b0;
            if (!w[7] && k.l4_ports[15:0] !== e.l4_ports[15:0]) return 1'b0;
            return 1'b1;
        endfunction

        function void note_input(in_item_t b);
            out_item_t r;
            entry_t    e;
            int        best;
            bit        found;
            r = '0;
            best = 0;
            found = 1'b0;
            case (cmd_t'(b.cmd))
                CMD_WRITE: begin
                    e.in_port = b.in_port;
                    e.src_mac = b.src_mac;
                    e.dst_mac = b.dst_mac;
                    e.vlan = b.vlan_info;
                    e.eth_type = b.eth_type;
                    e.tos_proto = b.tos_proto;
                    e.ip_pair = b.ip_pair;
                    e.l4_ports = b.l4_ports;
                    e.wildcards = b.wild_mask;
                    e.prio = b.prio_action[31:16];
                    e.out_port = b.prio_action[15:0];
                    table_q[b.slot] = e;
                    live[b.slot] = 1'b1;
                end
                CMD_CLEAR: live[b.slot] = 1'b0;
                CMD_LOOKUP: begin
                    lookups++;
                    for (int i = 0; i < Depth; i++) begin
                        if (live[i] && key_matches(table_q[i], b)) begin
                            if (table_q[i].wildcards == 0) begin
                                best = i;
                                found = 1'b1;
                                r.exact = 1'b1;
                                break;
                            end
                            if (!found || table_q[i].prio >= table_q[best].prio) begin
                                best = i;
                                found = 1'b1;
                            end
                        end
                    end
                    if (found) begin
                        hits++;
                        if (r.exact) exact_hits++;
                        r.hit = 1'b1;
                        r.hit_index = best[3:0];
                        r.out_port = table_q[best].out_port;
                        r.hit_priority = table_q[best].prio;
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("MISMATCH %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing expected", 0, 0);
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
            if (got.exact !== want.exact) report_mismatch("exact", got.exact, want.exact);
            if (got.hit_index !== want.hit_index)
                report_mismatch("hit_index", got.hit_index, want.hit_index);
            if (got.out_port !== want.out_port)
                report_mismatch("out_port", got.out_port, want.out_port);
            if (got.hit_priority !== want.hit_priority)
                report_mismatch("hit_priority", got.hit_priority, want.hit_priority);
        endtask
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    flow_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  quiet_cycles;
    bit  timed_out;
    entry_t keys[Depth];

    flow_table_wildcard_lookup i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_input(s_data);
            if (m_valid && m_ready) board.check_result(m_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic in_item_t random_beat();
        in_item_t b;
        b.cmd = 2'($urandom);
        b.slot = 4'($urandom);
        b.in_port = 16'($urandom);
        b.src_mac = {16'($urandom), 32'($urandom)};
        b.dst_mac = {16'($urandom), 32'($urandom)};
        b.vlan_info = 19'($urandom);
        b.eth_type = 16'($urandom);
        b.tos_proto = 16'($urandom);
        b.ip_pair = {32'($urandom), 32'($urandom)};
        b.l4_ports = 32'($urandom);
        b.wild_mask = 22'($urandom);
        b.prio_action = 32'($urandom);
        return b;
    endfunction

    // Valid stays high after the beat is taken; the next beat, an idle cycle
    // or the drain task lowers or reloads it.
    task automatic send_beat(input in_item_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0 && !timed_out) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // Builds a beat whose key fields track a stored entry, with some fields
    // disturbed so that wildcards and prefixes decide the outcome.
    function automatic in_item_t lookup_near(input int idx);
        in_item_t b;
        entry_t   e;
        b = random_beat();
        e = keys[idx];
        b.cmd = CMD_LOOKUP;
        if ($urandom_range(3) != 0) b.in_port = e.in_port;
        if ($urandom_range(3) != 0) b.src_mac = e.src_mac;
        if ($urandom_range(3) != 0) b.dst_mac = e.dst_mac;
        if ($urandom_range(3) != 0) b.vlan_info = e.vlan;
        if ($urandom_range(3) != 0) b.eth_type = e.eth_type;
        if ($urandom_range(3) != 0) b.tos_proto = e.tos_proto;
        if ($urandom_range(3) != 0) b.ip_pair = e.ip_pair ^ 64'($urandom_range(255));
        if ($urandom_range(3) != 0) b.l4_ports = e.l4_ports;
        return b;
    endfunction

    task automatic write_entry(input int idx, input bit sparse_wild);
        in_item_t b;
        b = random_beat();
        b.cmd = CMD_WRITE;
        b.slot = idx[3:0];
        if (sparse_wild) begin
            b.wild_mask = b.wild_mask & 22'($urandom) & 22'($urandom);
            if ($urandom_range(3) == 0) b.wild_mask = '0;
        end
        b.prio_action[31:16] = 16'($urandom_range(7));
        keys[idx].in_port = b.in_port;
        keys[idx].src_mac = b.src_mac;
        keys[idx].dst_mac = b.dst_mac;
        keys[idx].vlan = b.vlan_info;
        keys[idx].eth_type = b.eth_type;
        keys[idx].tos_proto = b.tos_proto;
        keys[idx].ip_pair = b.ip_pair;
        keys[idx].l4_ports = b.l4_ports;
        send_beat(b);
    endtask

    task automatic directed_part();
        in_item_t b;
        b = '0;
        b.cmd = CMD_LOOKUP;
        send_beat(b);
        b = '1;
        b.cmd = CMD_LOOKUP;
        send_beat(b);
        b = '1;
        b.cmd = CMD_NONE;
        send_beat(b);
        b = '0;
        b.cmd = CMD_WRITE;
        b.slot = 4'd15;
        b.wild_mask = '0;
        b.prio_action = 32'h0000_0007;
        send_beat(b);
        b.cmd = CMD_LOOKUP;
        send_beat(b);
        b = '1;
        b.cmd = CMD_WRITE;
        b.slot = 4'd3;
        b.prio_action = 32'hffff_ffff;
        send_beat(b);
        b.cmd = CMD_LOOKUP;
        send_beat(b);
        b = '0;
        b.cmd = CMD_WRITE;
        b.slot = 4'd5;
        b.wild_mask = 22'h0fffff;
        b.ip_pair = 64'hc0a8_0100_0a00_0000;
        b.wild_mask[13:8] = 6'd8;
        b.wild_mask[19:14] = 6'd32;
        b.prio_action = 32'hffff_0005;
        send_beat(b);
        b.cmd = CMD_LOOKUP;
        b.ip_pair = 64'hc0a8_01ff_1234_5678;
        send_beat(b);
        b.ip_pair = 64'hc0a8_02ff_1234_5678;
        send_beat(b);
        b = '0;
        b.cmd = CMD_WRITE;
        b.slot = 4'd6;
        b.wild_mask = 22'h3ffffd;
        b.wild_mask[20] = 1'b0;
        b.vlan_info = 19'h5_0064;
        b.prio_action = 32'hffff_0006;
        send_beat(b);
        b.cmd = CMD_LOOKUP;
        b.vlan_info = 19'h3_0064;
        send_beat(b);
        b = '0;
        b.cmd = CMD_CLEAR;
        b.slot = 4'd0;
        send_beat(b);
        b.slot = 4'd15;
        send_beat(b);
        b.slot = 4'd3;
        send_beat(b);
        b.slot = 4'd5;
        send_beat(b);
        b.slot = 4'd6;
        send_beat(b);
        b = random_beat();
        b.cmd = CMD_LOOKUP;
        send_beat(b);
        b = '0;
        b.cmd = CMD_WRITE;
        b.slot = 4'd2;
        b.wild_mask = '1;
        send_beat(b);
        b.cmd = CMD_LOOKUP;
        send_beat(b);
        drain();
    endtask

    task automatic random_phase(input int count);
        in_item_t b;
        int       pick;
        for (int n = 0; n < count && !timed_out; n++) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                write_entry($urandom_range(Depth - 1), 1'b1);
            end else if (pick < 25) begin
                b = random_beat();
                b.cmd = CMD_CLEAR;
                send_beat(b);
            end else if (pick < 85) begin
                send_beat(lookup_near($urandom_range(Depth - 1)));
            end else begin
                send_beat(random_beat());
            end
        end
        drain();
    endtask

    initial begin
        board = new();
        board.clear_table();
        for (int i = 0; i < Depth; i++) keys[i] = '0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        send_idle_pct = 8;
        recv_idle_pct = 67;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_part();
        random_phase(400);
        send_idle_pct = 67;
        recv_idle_pct = 8;
        random_phase(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(400);
        $display("Covered %0d lookups: %0d hits, %0d exact hits, plus writes, clears",
                 board.lookups, board.hits, board.exact_hits);
        $display("and unused commands under three handshake pacing mixes.");
        if (!timed_out && board.errors == 0 && board.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        wait (quiet_cycles >= WatchdogLimit);
        timed_out = 1'b1;
        $display("Watchdog expired with %0d results outstanding.", board.pending.size());
        $display("== FAIL ==");
        $finish;
    end
endmodule

@@ flow_table_wildcard_lookup.f @@
+incdir+rtl
rtl/ftwl_pkg.sv
rtl/ftwl_queue.sv
rtl/ftwl_engine.sv
rtl/flow_table_wildcard_lookup.sv
verif/testbench.sv
